FILE: src/sbt_pkg.sv
// Shared codes, state type and widths for the sorted bitset table.
package sbt_pkg;

  // Item kinds
  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;
  localparam logic [1:0] KIND_READ   = 2'd3;

  // Result status codes
  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_FULL = 2'd1;
  localparam logic [1:0] STATUS_POS  = 2'd2;

  // Width of one set word
  localparam int WORD_BITS = 64;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PLACE,
    ST_SHIFT,
    ST_RDWAIT,
    ST_FINISH
  } state_t;

endpackage

FILE: src/sbt_if.sv
// Request and response channel interfaces of the sorted bitset table.
interface sbt_req_if
  import sbt_pkg::*;
;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [1:0] word_index;
  word_t      word_value;
  logic [3:0] position;

  modport source (output valid, output kind, output word_index, output word_value,
                  output position, input ready);
  modport sink (input valid, input kind, input word_index, input word_value,
                input position, output ready);
endinterface

interface sbt_rsp_if
  import sbt_pkg::*;
;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [3:0] placed_at;
  logic [4:0] entry_count;
  word_t      read_word;

  modport source (output valid, output status, output placed_at, output entry_count,
                  output read_word, input ready);
  modport sink (input valid, input status, input placed_at, input entry_count,
                input read_word, output ready);
endinterface

FILE: src/sbt_ram.sv
// Simple dual-port entry memory: one write port, one registered read port.
module sbt_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wa,
  input  logic [WIDTH-1:0]         wd,
  input  logic [$clog2(DEPTH)-1:0] ra,
  output logic [WIDTH-1:0]         rd
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  // Read one word through a registered output
  always_ff @(posedge clk) begin
    rd <= mem[ra];
  end

endmodule

FILE: src/sbt_staging.sv
// Staging set memory; words never loaded since reset read as zero.
module sbt_staging
  import sbt_pkg::*;
#(
  parameter int SET_WORDS = 4
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         we,
  input  logic [((SET_WORDS > 1) ? $clog2(SET_WORDS) : 1)-1:0] wa,
  input  word_t                                        wd,
  input  logic [((SET_WORDS > 1) ? $clog2(SET_WORDS) : 1)-1:0] ra,
  output word_t                                        rd
);

  word_t mem [SET_WORDS];
  logic  vld [SET_WORDS];

  // Write one word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  // Mark loaded words, clear all marks at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SET_WORDS; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (we) begin
      vld[wa] <= 1'b1;
    end
  end

  // Read one word through a registered output; unloaded words read as zero
  always_ff @(posedge clk) begin
    rd <= vld[ra] ? mem[ra] : '0;
  end

endmodule

FILE: src/sorted_bitset_table.sv
// Sorted bitset table: keeps bitset entries in descending set order in one word-wide memory.
//
// Items arrive as beats on req and each produces exactly one beat on rsp.
// A load writes one word of the staging set; an insert places the staging
// set after every entry that is not less; a remove closes the gap at a
// position; a read returns one word of an entry.
// An insert copies entries up from the top, comparing each with the staging
// set, until one is not less or the bottom is reached, then writes the
// staging set into the opened slot; a remove moves each entry after the
// removed one down a slot. Within an entry, the single read port of the
// entry memory has one word fetched, compared and written back each cycle.
// req.ready is high only while no item is in progress. The result waits in
// an output register; the next item is taken while it waits, but a finished
// item holds in its final state until that register is free.
// Reset empties the table and zeroes the staging set at once; no clearing
// pass runs, the entry memory needs none.
module sorted_bitset_table
  import sbt_pkg::*;
#(
  parameter int SET_WORDS     = 4,
  parameter int TABLE_ENTRIES = 16
) (
  input logic       clk,
  input logic       rst,
  sbt_req_if.sink   req,
  sbt_rsp_if.source rsp
);

  localparam int WW    = (SET_WORDS > 1) ? $clog2(SET_WORDS) : 1;
  localparam int EW    = $clog2(TABLE_ENTRIES);
  localparam int CW    = $clog2(TABLE_ENTRIES + 1);
  localparam int DEPTH = TABLE_ENTRIES * SET_WORDS;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = ((CW > 4) ? CW : 4) + 1;
  localparam logic [WW-1:0] WLAST    = WW'(SET_WORDS - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_ENTRIES);

  function automatic logic [AW-1:0] addr_of(input logic [EW-1:0] e, input logic [WW-1:0] w);
    return AW'(AW'(e) * AW'(SET_WORDS)) + AW'(w);
  endfunction

  state_t        state, state_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [CW-1:0] p, p_next;
  logic [CW-1:0] src_e;
  logic          iss_on, iss_on_next;
  logic [WW-1:0] iw, iw_next;
  logic          issue;
  logic          dv;
  logic [WW-1:0] dw;
  logic          dec, dec_next;
  logic          abv, abv_next;
  logic [1:0]    res_status, res_status_next;
  logic [3:0]    res_placed, res_placed_next;
  word_t         res_word, res_word_next;
  logic          out_load;
  logic          out_valid;
  logic [1:0]    out_status;
  logic [3:0]    out_placed;
  logic [4:0]    out_count;
  word_t         out_word;

  logic          mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  word_t         mem_wd, mem_rd;
  logic          stg_we;
  logic [WW-1:0] stg_wa, stg_ra;
  word_t         stg_rd;

  logic          accept;
  logic          widx_ok, pos_bad, pos_last;
  word_t         diff, low;
  logic          hit, gt, final_above;

  sbt_ram #(
    .DEPTH(DEPTH),
    .WIDTH(WORD_BITS)
  ) u_entry (
    .clk(clk),
    .we (mem_we),
    .wa (mem_wa),
    .wd (mem_wd),
    .ra (mem_ra),
    .rd (mem_rd)
  );

  sbt_staging #(
    .SET_WORDS(SET_WORDS)
  ) u_staging (
    .clk(clk),
    .rst(rst),
    .we (stg_we),
    .wa (stg_wa),
    .wd (req.word_value),
    .ra (stg_ra),
    .rd (stg_rd)
  );

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;

  // Decode the request against the table
  assign widx_ok  = (7'(req.word_index) < 7'(SET_WORDS));
  assign pos_bad  = (XW'(req.position) >= XW'(cnt));
  assign pos_last = ((XW'(req.position) + XW'(1)) >= XW'(cnt));

  // Compare one entry word with the staging word: lowest differing bit decides
  assign diff        = mem_rd ^ stg_rd;
  assign low         = diff & (~diff + WORD_BITS'(1));
  assign hit         = (diff != '0);
  assign gt          = ((stg_rd & low) != '0);
  assign final_above = dec ? abv : (hit && gt);

  // Entry that the read side walks
  always_comb begin
    case (state)
      ST_SCAN:  src_e = p - CW'(1);
      ST_SHIFT: src_e = p + CW'(1);
      default:  src_e = p;
    endcase
  end

  // Sequencer: next state, memory controls and result fields
  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    p_next          = p;
    iss_on_next     = iss_on;
    iw_next         = iw;
    dec_next        = dec;
    abv_next        = abv;
    res_status_next = res_status;
    res_placed_next = res_placed;
    res_word_next   = res_word;
    issue           = 1'b0;
    out_load        = 1'b0;
    mem_we          = 1'b0;
    mem_wa          = addr_of(p[EW-1:0], dw);
    mem_wd          = mem_rd;
    mem_ra          = addr_of(src_e[EW-1:0], iw);
    stg_we          = 1'b0;
    stg_wa          = WW'(req.word_index);
    stg_ra          = iw;

    // Advance the word issue counter
    if ((state == ST_SCAN || state == ST_PLACE || state == ST_SHIFT) && iss_on) begin
      issue = 1'b1;
      if (iw == WLAST) begin
        iss_on_next = 1'b0;
        iw_next     = '0;
      end else begin
        iw_next = iw + WW'(1);
      end
    end

    case (state)
      ST_IDLE: begin
        if (accept) begin
          res_status_next = STATUS_OK;
          res_placed_next = '0;
          res_word_next   = '0;
          dec_next        = 1'b0;
          iw_next         = '0;
          state_next      = ST_FINISH;
          case (req.kind)
            KIND_LOAD: begin
              stg_we = widx_ok;
            end
            KIND_INSERT: begin
              if (cnt == FULL_CNT) begin
                res_status_next = STATUS_FULL;
              end else begin
                p_next      = cnt;
                iss_on_next = 1'b1;
                state_next  = (cnt == '0) ? ST_PLACE : ST_SCAN;
              end
            end
            KIND_REMOVE: begin
              if (pos_bad) begin
                res_status_next = STATUS_POS;
              end else if (pos_last) begin
                cnt_next = cnt - CW'(1);
              end else begin
                p_next      = CW'(req.position);
                iss_on_next = 1'b1;
                state_next  = ST_SHIFT;
              end
            end
            KIND_READ: begin
              if (pos_bad) begin
                res_status_next = STATUS_POS;
              end else if (widx_ok) begin
                mem_ra     = addr_of(EW'(req.position), WW'(req.word_index));
                state_next = ST_RDWAIT;
              end
            end
            default: begin
              state_next = ST_FINISH;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // Copy entry p-1 up into p while comparing it with the staging set
        if (dv) begin
          mem_we = 1'b1;
          if (!dec && hit) begin
            dec_next = 1'b1;
            abv_next = gt;
          end
          if (dw == WLAST) begin
            dec_next    = 1'b0;
            iss_on_next = 1'b1;
            iw_next     = '0;
            if (final_above) begin
              p_next = p - CW'(1);
              if (p == CW'(1)) begin
                state_next = ST_PLACE;
              end
            end else begin
              state_next = ST_PLACE;
            end
          end
        end
      end

      ST_PLACE: begin
        // Write the staging set into the opened slot
        if (dv) begin
          mem_we = 1'b1;
          mem_wd = stg_rd;
          if (dw == WLAST) begin
            cnt_next        = cnt + CW'(1);
            res_placed_next = 4'(p);
            state_next      = ST_FINISH;
          end
        end
      end

      ST_SHIFT: begin
        // Move entry p+1 down into p
        if (dv) begin
          mem_we = 1'b1;
          if (dw == WLAST) begin
            if ((p + CW'(2)) >= cnt) begin
              cnt_next   = cnt - CW'(1);
              state_next = ST_FINISH;
            end else begin
              p_next      = p + CW'(1);
              iss_on_next = 1'b1;
              iw_next     = '0;
            end
          end
        end
      end

      ST_RDWAIT: begin
        res_word_next = mem_rd;
        state_next    = ST_FINISH;
      end

      ST_FINISH: begin
        // Hand the result over once the output register is free
        if (!out_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      cnt    <= '0;
      iss_on <= 1'b0;
      dv     <= 1'b0;
    end else begin
      state  <= state_next;
      cnt    <= cnt_next;
      iss_on <= iss_on_next;
      dv     <= issue;
    end
  end

  // Walk position, word tags, compare decision and result fields
  always_ff @(posedge clk) begin
    p          <= p_next;
    iw         <= iw_next;
    dw         <= iw;
    dec        <= dec_next;
    abv        <= abv_next;
    res_status <= res_status_next;
    res_placed <= res_placed_next;
    res_word   <= res_word_next;
  end

  // Output register: hold the beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= res_status;
      out_placed <= res_placed;
      out_count  <= 5'(cnt);
      out_word   <= res_word;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.placed_at   = out_placed;
  assign rsp.entry_count = out_count;
  assign rsp.read_word   = out_word;

endmodule

FILE: src/sbt_chk.sv
// Port-level checks of the sorted bitset table, bound to its top level.
module sbt_chk
  import sbt_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [1:0] rsp_status,
  input logic [3:0] rsp_placed_at,
  input logic [4:0] rsp_entry_count,
  input word_t      rsp_read_word
);

  logic [1:0] pend;
  logic       acc, del;

  assign acc = req_valid && req_ready;
  assign del = rsp_valid && rsp_ready;

  // Track items taken but not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else begin
      pend <= pend + 2'(acc) - 2'(del);
    end
  end

  a_no_orphan_beat: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (pend != 2'd0))
    else $error("result beat with no item outstanding");

  a_pend_bound: assert property (@(posedge clk) disable iff (rst)
    pend != 2'd3)
    else $error("more than two items outstanding");

  a_flag_clean: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp_status == STATUS_FULL || rsp_status == STATUS_POS))
      |-> (rsp_placed_at == 4'd0 && rsp_read_word == '0))
    else $error("flagged result carries placement or data");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status)
      && $stable(rsp_placed_at) && $stable(rsp_entry_count) && $stable(rsp_read_word)))
    else $error("stalled result beat changed");

endmodule

bind sorted_bitset_table sbt_chk u_sbt_chk (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_status     (rsp.status),
  .rsp_placed_at  (rsp.placed_at),
  .rsp_entry_count(rsp.entry_count),
  .rsp_read_word  (rsp.read_word)
);
